/* rtl/integer_to_radix_digits_macros.svh */
// Assertion macros for the integer_to_radix_digits block.
// Included by RTL files that carry concurrent checks; no other dependencies.
`ifndef INTEGER_TO_RADIX_DIGITS_MACROS_SVH
`define INTEGER_TO_RADIX_DIGITS_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define I2RD_ASSERT(label, clk, rstn, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// condition must never be seen outside reset
`define I2RD_NEVER(label, clk, rstn, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define I2RD_ASSERT(label, clk, rstn, prop, msg)
`define I2RD_NEVER(label, clk, rstn, cond, msg)
`endif
`endif

/* rtl/i2rd_pkg.sv */
// Shared types, constants and the digit-to-ASCII mapping for integer_to_radix_digits.
// No dependencies.
package i2rd_pkg;

	localparam int RADIX_W = 6;
	localparam int DIGIT_W = 6;
	localparam int CHAR_W  = 7;

	localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
	localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

	localparam logic [DIGIT_W-1:0] DIGIT_NINE = 6'd9;
	localparam logic [DIGIT_W-1:0] DIGIT_TEN  = 6'd10;
	localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 7'h30; // '0'
	localparam logic [CHAR_W-1:0]  CHAR_A     = 7'h61; // 'a'

	// classification of one number, made in the front part
	typedef struct packed {
		logic [RADIX_W-1:0] radix;   // clamped radix, 2..36
		logic               is_zero; // value is zero: single '0'
	} cls_t;

	function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] c;
		if (d <= DIGIT_NINE) begin
			c = CHAR_ZERO + CHAR_W'(d);
		end else begin
			c = CHAR_A + CHAR_W'(d - DIGIT_TEN);
		end
		return c;
	endfunction

endpackage

/* rtl/integer_to_radix_digits.sv */
// Top level of integer_to_radix_digits: front, queue and back parts wired together.
// Depends on i2rd_pkg, i2rd_front, i2rd_queue and i2rd_back.
//
//  channel  | ports                              | handshake
//  ---------+------------------------------------+-------------------------------
//  config   | radix_we, radix_wdata              | write at edge with radix_we high
//  command  | start, value, busy                 | beat at edge with start & !busy
//  result   | strobe, digit_char, last_digit     | beat on every strobe cycle
//
// In the back part, the bit-serial divider makes one quotient bit per cycle, and each
// emitted character takes one read of the digit store; a zero skips the divider.
// The first character shows in the cycle after the emit phase starts; characters then follow
// on consecutive cycles, most significant first.
// Reset (arst_n low) clears the queue and sequencer and sets radix to 10; the digit store
// is always written before it is read and needs no clearing.
// busy rises only when the two-entry queue is full; results cannot be stalled.
module integer_to_radix_digits #(
	parameter int VALUE_WIDTH = 32,
	parameter int MAX_DIGITS  = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         radix_we,
	input  logic [i2rd_pkg::RADIX_W-1:0] radix_wdata,
	input  logic                         start,
	input  logic [VALUE_WIDTH-1:0]       value,
	output logic                         busy,
	output logic                         strobe,
	output logic [i2rd_pkg::CHAR_W-1:0]  digit_char,
	output logic                         last_digit
);

	// front -> queue
	logic                          push;
	logic [VALUE_WIDTH-1:0]        push_value;
	i2rd_pkg::cls_t                push_cls;
	logic                          q_full;

	// queue -> back
	logic                          q_valid;
	logic [VALUE_WIDTH-1:0]        q_value;
	i2rd_pkg::cls_t                q_cls;
	logic                          pop;

	// back -> result port
	logic [i2rd_pkg::DIGIT_W-1:0]  digit;

	i2rd_front #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.radix_we    (radix_we),
		.radix_wdata (radix_wdata),
		.start       (start),
		.value       (value),
		.q_full      (q_full),
		.busy        (busy),
		.push        (push),
		.push_value  (push_value),
		.push_cls    (push_cls)
	);

	// lets the front take new numbers while the back is still dividing
	i2rd_queue #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_value (push_value),
		.push_cls   (push_cls),
		.pop        (pop),
		.full       (q_full),
		.valid      (q_valid),
		.pop_value  (q_value),
		.pop_cls    (q_cls)
	);

	i2rd_back #(
		.VALUE_WIDTH (VALUE_WIDTH),
		.MAX_DIGITS  (MAX_DIGITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_value (q_value),
		.q_cls   (q_cls),
		.pop     (pop),
		.strobe  (strobe),
		.digit   (digit),
		.last    (last_digit)
	);

	// digit value to ASCII: '0'-'9', then 'a' onward
	assign digit_char = i2rd_pkg::digit_to_char(digit);

endmodule

/* rtl/i2rd_front.sv */
// Front part: radix register, command accept and classification of each number.
// Depends on i2rd_pkg.
module i2rd_front #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          radix_we,
	input  logic [i2rd_pkg::RADIX_W-1:0]  radix_wdata,
	input  logic                          start,
	input  logic [VALUE_WIDTH-1:0]        value,
	input  logic                          q_full,
	output logic                          busy,
	output logic                          push,
	output logic [VALUE_WIDTH-1:0]        push_value,
	output i2rd_pkg::cls_t                push_cls
);

	logic [i2rd_pkg::RADIX_W-1:0] radix_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= i2rd_pkg::RADIX_RESET;
		end else if (radix_we) begin
			radix_q <= radix_wdata;
		end
	end

	assign busy       = q_full;
	assign push       = start && !q_full;
	assign push_value = value;

	always_comb begin
		if (radix_q < i2rd_pkg::RADIX_MIN) begin
			push_cls.radix = i2rd_pkg::RADIX_MIN;
		end else if (radix_q > i2rd_pkg::RADIX_MAX) begin
			push_cls.radix = i2rd_pkg::RADIX_MAX;
		end else begin
			push_cls.radix = radix_q;
		end
		push_cls.is_zero = (value == '0);
	end

endmodule

/* rtl/i2rd_queue.sv */
// Two-entry queue of classified numbers between front and back parts.
// Depends on i2rd_pkg.
module i2rd_queue #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  logic [VALUE_WIDTH-1:0] push_value,
	input  i2rd_pkg::cls_t         push_cls,
	input  logic                   pop,
	output logic                   full,
	output logic                   valid,
	output logic [VALUE_WIDTH-1:0] pop_value,
	output i2rd_pkg::cls_t         pop_cls
);

	logic [VALUE_WIDTH-1:0] val_q [2];
	i2rd_pkg::cls_t         cls_q [2];
	logic                   wr_ptr_q;
	logic                   rd_ptr_q;
	logic [1:0]             count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			val_q[wr_ptr_q] <= push_value;
			cls_q[wr_ptr_q] <= push_cls;
		end
	end

	assign full      = (count_q == 2'd2);
	assign valid     = (count_q != 2'd0);
	assign pop_value = val_q[rd_ptr_q];
	assign pop_cls   = cls_q[rd_ptr_q];

endmodule

/* rtl/i2rd_back.sv */
// Back part: bit-serial radix divider, digit store and MSB-first digit emitter.
// Depends on i2rd_pkg and integer_to_radix_digits_macros.svh.
`include "integer_to_radix_digits_macros.svh"
module i2rd_back #(
	parameter int VALUE_WIDTH = 32,
	parameter int MAX_DIGITS  = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	input  logic [VALUE_WIDTH-1:0]        q_value,
	input  i2rd_pkg::cls_t                q_cls,
	output logic                          pop,
	output logic                          strobe,
	output logic [i2rd_pkg::DIGIT_W-1:0]  digit,
	output logic                          last
);

	localparam int CNT_W  = $clog2(VALUE_WIDTH);
	localparam int NDIG_W = $clog2(MAX_DIGITS + 1);
	localparam int ADDR_W = $clog2(MAX_DIGITS);
	localparam int SH_W   = i2rd_pkg::RADIX_W + 1;

	typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_EMIT} state_t;

	state_t                        state_q;
	logic [CNT_W-1:0]              cnt_q;
	logic [VALUE_WIDTH-1:0]        dvd_q;
	logic [i2rd_pkg::RADIX_W-1:0]  rem_q;
	logic [i2rd_pkg::RADIX_W-1:0]  radix_q;
	logic [NDIG_W-1:0]             ndig_q;
	logic [ADDR_W-1:0]             rd_addr_q;
	logic                          rd_valid_s1;
	logic                          rd_last_s1;
	logic [i2rd_pkg::DIGIT_W-1:0]  rd_data_s1;

	logic [i2rd_pkg::DIGIT_W-1:0]  mem [MAX_DIGITS];

	// one restoring division step
	logic [SH_W-1:0]               shifted;
	logic                          ge;
	logic [i2rd_pkg::RADIX_W-1:0]  rem_n;
	logic [VALUE_WIDTH-1:0]        dvd_n;
	logic                          div_last;
	logic [NDIG_W-1:0]             ndig_n;
	logic                          div_done;
	logic                          wr_en;
	logic [ADDR_W-1:0]             wr_addr;
	logic [i2rd_pkg::DIGIT_W-1:0]  wr_data;
	logic                          rd_en;

	always_comb begin
		shifted  = {rem_q, dvd_q[VALUE_WIDTH-1]};
		ge       = (shifted >= {1'b0, radix_q});
		rem_n    = ge ? i2rd_pkg::RADIX_W'(shifted - {1'b0, radix_q})
		              : shifted[i2rd_pkg::RADIX_W-1:0];
		dvd_n    = {dvd_q[VALUE_WIDTH-2:0], ge};
		div_last = (state_q == ST_DIV) && (cnt_q == CNT_W'(VALUE_WIDTH - 1));
		ndig_n   = ndig_q + NDIG_W'(1);
		div_done = (dvd_n == '0) || (ndig_n == NDIG_W'(MAX_DIGITS));
	end

	assign pop = (state_q == ST_IDLE) && q_valid;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = ndig_q[ADDR_W-1:0];
		wr_data = rem_n;
		if (div_last) begin
			wr_en = 1'b1;
		end else if (pop && q_cls.is_zero) begin
			wr_en   = 1'b1;
			wr_addr = '0;
			wr_data = '0;
		end
	end

	assign rd_en = (state_q == ST_EMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			dvd_q       <= '0;
			rem_q       <= '0;
			radix_q     <= i2rd_pkg::RADIX_RESET;
			ndig_q      <= '0;
			rd_addr_q   <= '0;
			rd_valid_s1 <= 1'b0;
			rd_last_s1  <= 1'b0;
		end else begin
			rd_valid_s1 <= (state_q == ST_EMIT);
			rd_last_s1  <= (state_q == ST_EMIT) && (rd_addr_q == '0);
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						radix_q <= q_cls.radix;
						dvd_q   <= q_value;
						rem_q   <= '0;
						cnt_q   <= '0;
						ndig_q  <= '0;
						if (q_cls.is_zero) begin
							rd_addr_q <= '0;
							state_q   <= ST_EMIT;
						end else begin
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (div_last) begin
						// digit done: keep quotient, restart remainder
						dvd_q  <= dvd_n;
						rem_q  <= '0;
						cnt_q  <= '0;
						ndig_q <= ndig_n;
						if (div_done) begin
							rd_addr_q <= ndig_q[ADDR_W-1:0];
							state_q   <= ST_EMIT;
						end
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
						dvd_q <= dvd_n;
						rem_q <= rem_n;
					end
				end
				ST_EMIT: begin
					if (rd_addr_q == '0) begin
						state_q <= ST_IDLE;
					end else begin
						rd_addr_q <= rd_addr_q - ADDR_W'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr_q];
		end
	end

	assign strobe = rd_valid_s1;
	assign digit  = rd_data_s1;
	assign last   = rd_last_s1;

	`I2RD_ASSERT(a_rem_below_radix, clk, arst_n, (state_q == ST_DIV) |-> (rem_q < radix_q), "remainder reached radix")
	`I2RD_ASSERT(a_digits_contiguous, clk, arst_n, (rd_valid_s1 && !rd_last_s1) |=> rd_valid_s1, "gap inside a number")
	`I2RD_ASSERT(a_gap_after_last, clk, arst_n, (rd_valid_s1 && rd_last_s1) |=> !rd_valid_s1, "beat right after last digit")
	`I2RD_NEVER(n_digit_range, clk, arst_n, rd_valid_s1 && (rd_data_s1 >= radix_q), "digit not below radix")

endmodule
